// ===== sv/tpid_pkg.sv =====
// Shared types and constants of the thermocouple PID phase controller.
package tpid_pkg;

    localparam int RAW_W    = 32;
    localparam int TEMP_W   = 14;
    localparam int TEMP_LSB = 18;
    localparam int FAULT_W  = 3;
    localparam int ERR_W    = 16;
    localparam int DIFF_W   = 17;
    localparam int GAIN_W   = 24;
    localparam int DUTY_W   = 17;
    localparam int DELAY_W  = 14;
    localparam int ADDR_W   = 2;

    // Shared multiplier: 25 x 25 signed.
    localparam int MUL_W    = 25;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 45;

    // Integral magnitude is split into two 24-bit halves.
    localparam int MAG_W    = 48;
    localparam int HALF_W   = 24;
    localparam int PART_W   = 48;
    localparam int TERM_W   = 43;
    localparam int SAT_BIT  = 18;

    localparam logic [TERM_W-1:0] TERM_LIMIT   = TERM_W'(64'd1 << 42);
    localparam int                DUTY_FULL    = 65536;
    localparam int                HALF_CYCLE_US = 8300;
    localparam int                DELAY_LSB    = 16;

    localparam logic [TEMP_W-1:0] SETPOINT_RST   = TEMP_W'(720);
    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = GAIN_W'(524288);
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = GAIN_W'(3932);
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = GAIN_W'(1310720);

    typedef enum logic [ADDR_W-1:0] {
        REG_SETPOINT   = 2'd0,
        REG_GAIN_PROP  = 2'd1,
        REG_GAIN_INTEG = 2'd2,
        REG_GAIN_DERIV = 2'd3
    } t_reg_idx;

    // One classified request as it travels from front to back.
    typedef struct packed {
        logic                      fault;
        logic [FAULT_W-1:0]        fault_bits;
        logic signed [TEMP_W-1:0]  temp;
        logic signed [ERR_W-1:0]   err;
    } t_item;

    // Gain set handed to the back end.
    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } t_gains;

endpackage

// ===== sv/tpid_front.sv =====
// Front end: decode the raw converter word and classify it as fault or sample.
module tpid_front
    import tpid_pkg::*;
(
    input  logic                     i_push,
    input  logic [RAW_W-1:0]         i_raw_word,
    input  logic signed [TEMP_W-1:0] i_setpoint,
    input  logic                     i_q_full,
    output logic                     o_full,
    output logic                     o_wr_en,
    output t_item                    o_item
);

    logic signed [TEMP_W-1:0] temp;
    logic [FAULT_W-1:0]       fbits;

    always_comb begin
        fbits = i_raw_word[FAULT_W-1:0];
        temp  = signed'(i_raw_word[TEMP_LSB +: TEMP_W]);

        o_item.fault      = |fbits;
        o_item.fault_bits = fbits;
        o_item.temp       = temp;
        // Error in quarter degrees; always fits 16 bits.
        o_item.err        = ERR_W'(i_setpoint) - ERR_W'(temp);
    end

    assign o_full  = i_q_full;
    assign o_wr_en = i_push && !i_q_full;

endmodule

// ===== sv/tpid_fifo.sv =====
// Short request queue between front and back ends.
module tpid_fifo
    import tpid_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_en,
    input  t_item i_wr_item,
    input  logic  i_rd_en,
    output t_item o_rd_item,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic do_wr;
    logic do_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_item = r_mem[r_rd_ptr];
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/tpid_back.sv =====
// Back end: PID step on one shared multiplier, clamp, phase mapping, result register.
module tpid_back
    import tpid_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = 32
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_gains                    i_gains,
    input  logic                      i_q_empty,
    input  t_item                     i_q_item,
    output logic                      o_q_rd,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic signed [TEMP_W-1:0]  o_temperature,
    output logic                      o_fault,
    output logic [FAULT_W-1:0]        o_fault_bits,
    output logic [DUTY_W-1:0]         o_duty,
    output logic [DELAY_W-1:0]        o_phase_delay_us
);

    localparam int IW    = INTEGRAL_WIDTH;
    localparam int SUM_W = IW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_D,
        S_MUL_IL,
        S_MUL_IH,
        S_ISAT,
        S_IACC,
        S_CLAMP,
        S_MUL_Y,
        S_DONE
    } t_state;

    t_state                    r_state;
    t_item                     r_item;
    logic signed [IW-1:0]      r_integ;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [DIFF_W-1:0]  r_d;
    logic [MAG_W-1:0]          r_mag;
    logic                      r_neg;
    logic signed [PROD_W-1:0]  r_prod;
    logic [PART_W-1:0]         r_lo;
    logic [TERM_W-1:0]         r_iterm;
    logic signed [ACC_W-1:0]   r_acc;
    logic [DUTY_W-1:0]         r_duty;
    logic [DUTY_W-1:0]         r_rem;
    logic                      r_out_valid;

    logic                      out_free;
    logic                      start;
    logic                      load_out;
    logic signed [MUL_W-1:0]   op_a;
    logic signed [MUL_W-1:0]   op_b;
    logic signed [PROD_W-1:0]  mult;
    logic signed [SUM_W-1:0]   isum;
    logic signed [IW-1:0]      integ_sat;
    logic [IW-1:0]             integ_abs;
    logic [PART_W-1:0]         ph;
    logic [PART_W:0]           isum_full;
    logic [TERM_W-1:0]         iterm;
    logic signed [ACC_W-1:0]   iterm_s;
    logic [ACC_W-3:0]          acc_q;
    logic [DUTY_W-1:0]         duty;

    assign out_free = !r_out_valid || i_pop;
    assign start    = (r_state == S_IDLE) && !i_q_empty && out_free;
    assign o_q_rd   = start;
    assign o_empty  = !r_out_valid;
    // A fault request or a finished sample loads the result register.
    assign load_out = (start && i_q_item.fault) || (r_state == S_DONE);

    // Operand select for the shared multiplier.
    always_comb begin
        case (r_state)
            S_MUL_P: begin
                op_a = MUL_W'(i_gains.prop);
                op_b = MUL_W'(r_item.err);
            end
            S_MUL_D: begin
                op_a = MUL_W'(i_gains.deriv);
                op_b = MUL_W'(r_d);
            end
            S_MUL_IL: begin
                op_a = MUL_W'(i_gains.integ);
                op_b = MUL_W'(r_mag[HALF_W-1:0]);
            end
            S_MUL_IH: begin
                op_a = MUL_W'(i_gains.integ);
                op_b = MUL_W'(r_mag[MAG_W-1:HALF_W]);
            end
            S_MUL_Y: begin
                op_a = MUL_W'(r_rem);
                op_b = MUL_W'(HALF_CYCLE_US);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        mult = op_a * op_b;
    end

    // Integral update with saturation, and its magnitude.
    always_comb begin
        isum = SUM_W'(r_integ) + SUM_W'(i_q_item.err);
        if (isum[IW] != isum[IW-1]) begin
            integ_sat = isum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end else begin
            integ_sat = isum[IW-1:0];
        end
        integ_abs = r_integ[IW-1] ? unsigned'(-r_integ) : unsigned'(r_integ);
    end

    // Integral term magnitude, saturated at the term limit.
    always_comb begin
        ph        = r_prod[PART_W-1:0];
        isum_full = {1'b0, r_lo} + {ph[SAT_BIT-1:0], {HALF_W{1'b0}}};
        if (|ph[PART_W-1:SAT_BIT]) begin
            iterm = TERM_LIMIT;
        end else if (isum_full > (PART_W+1)'(TERM_LIMIT)) begin
            iterm = TERM_LIMIT;
        end else begin
            iterm = isum_full[TERM_W-1:0];
        end
        iterm_s = ACC_W'(r_iterm);
    end

    // Clamp to 0..1 in Q16.
    always_comb begin
        acc_q = r_acc[ACC_W-1:2];
        if (r_acc[ACC_W-1] || r_acc == '0) begin
            duty = '0;
        end else if (acc_q > (ACC_W-2)'(DUTY_FULL)) begin
            duty = DUTY_W'(DUTY_FULL);
        end else begin
            duty = acc_q[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mult;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_prev_err  <= '0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_item <= i_q_item;
                        if (i_q_item.fault) begin
                            // Report the fault at once; state stays untouched.
                            o_temperature    <= '0;
                            o_fault          <= 1'b1;
                            o_fault_bits     <= i_q_item.fault_bits;
                            o_duty           <= '0;
                            o_phase_delay_us <= '0;
                        end else begin
                            r_integ    <= integ_sat;
                            r_d        <= DIFF_W'(i_q_item.err) - DIFF_W'(r_prev_err);
                            r_prev_err <= i_q_item.err;
                            r_state    <= S_MUL_P;
                        end
                    end
                end
                S_MUL_P: begin
                    r_neg   <= r_integ[IW-1];
                    r_mag   <= MAG_W'(integ_abs);
                    r_state <= S_MUL_D;
                end
                S_MUL_D: begin
                    r_acc   <= r_prod[ACC_W-1:0];
                    r_state <= S_MUL_IL;
                end
                S_MUL_IL: begin
                    r_acc   <= r_acc + r_prod[ACC_W-1:0];
                    r_state <= S_MUL_IH;
                end
                S_MUL_IH: begin
                    r_lo    <= r_prod[PART_W-1:0];
                    r_state <= S_ISAT;
                end
                S_ISAT: begin
                    r_iterm <= iterm;
                    r_state <= S_IACC;
                end
                S_IACC: begin
                    r_acc   <= r_neg ? r_acc - iterm_s : r_acc + iterm_s;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_duty  <= duty;
                    r_rem   <= DUTY_W'(DUTY_FULL) - duty;
                    r_state <= S_MUL_Y;
                end
                S_MUL_Y: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_temperature    <= r_item.temp;
                    o_fault          <= 1'b0;
                    o_fault_bits     <= '0;
                    o_duty           <= r_duty;
                    o_phase_delay_us <= r_prod[DELAY_LSB +: DELAY_W];
                    r_state          <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/thermocouple_pid_phase_controller_unit.sv =====
// Top level of the thermocouple PID phase controller: registers, front, queue, back.
//
// Usage:
//   Input channel: a raw 32-bit converter word is taken on each clock edge where push is
//   high and full is low. Result channel: while empty is low the oldest result sits on the
//   o_* result ports; pop with empty low takes it.
//   Configuration: write setpoint and gains through i_cfg_we / i_cfg_addr / i_cfg_wdata,
//   one register per cycle, only while no request is in flight.
//   Flow: a fault word is reported straight from the queue head. A good sample runs through
//   one shared 25x25 multiplier (proportional, derivative, two integral halves, phase
//   mapping) plus saturation and clamp steps before its result is registered; the back end
//   takes no new sample until then; fault words go one per cycle while results are popped.
//   The request queue (QUEUE_DEPTH entries) keeps accepting while the back end works.
//   Stall: a held result blocks the back end from starting the next request; the queue
//   then fills and full rises. Nothing is dropped.
//   Reset (synchronous, i_rst_n low): queue emptied, no result pending, integral and
//   previous error cleared, registers back to setpoint 720 and the default gains.
module thermocouple_pid_phase_controller_unit
    import tpid_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = 32,
    parameter int QUEUE_DEPTH    = 2
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [ADDR_W-1:0]         i_cfg_addr,
    input  logic [GAIN_W-1:0]         i_cfg_wdata,
    // request channel
    input  logic                      push,
    output logic                      full,
    input  logic [RAW_W-1:0]          i_raw_word,
    // result channel
    output logic                      empty,
    input  logic                      pop,
    output logic signed [TEMP_W-1:0]  o_temperature,
    output logic                      o_fault,
    output logic [FAULT_W-1:0]        o_fault_bits,
    output logic [DUTY_W-1:0]         o_duty,
    output logic [DELAY_W-1:0]        o_phase_delay_us
);

    logic signed [TEMP_W-1:0] r_setpoint;
    t_gains                   r_gains;

    logic  q_full;
    logic  q_empty;
    logic  q_wr;
    logic  q_rd;
    t_item wr_item;
    t_item rd_item;

    // Configuration registers; every index of the 2-bit address is a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint    <= SETPOINT_RST;
            r_gains.prop  <= GAIN_PROP_RST;
            r_gains.integ <= GAIN_INTEG_RST;
            r_gains.deriv <= GAIN_DERIV_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_SETPOINT:   r_setpoint    <= signed'(i_cfg_wdata[TEMP_W-1:0]);
                REG_GAIN_PROP:  r_gains.prop  <= i_cfg_wdata;
                REG_GAIN_INTEG: r_gains.integ <= i_cfg_wdata;
                REG_GAIN_DERIV: r_gains.deriv <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Decode and classify each request.
    tpid_front u_front (
        .i_push     (push),
        .i_raw_word (i_raw_word),
        .i_setpoint (r_setpoint),
        .i_q_full   (q_full),
        .o_full     (full),
        .o_wr_en    (q_wr),
        .o_item     (wr_item)
    );

    // Hold classified requests until the back end is free.
    tpid_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_wr),
        .i_wr_item (wr_item),
        .i_rd_en   (q_rd),
        .o_rd_item (rd_item),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    // Run the PID step and drive the result register.
    tpid_back #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_gains          (r_gains),
        .i_q_empty        (q_empty),
        .i_q_item         (rd_item),
        .o_q_rd           (q_rd),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_temperature    (o_temperature),
        .o_fault          (o_fault),
        .o_fault_bits     (o_fault_bits),
        .o_duty           (o_duty),
        .o_phase_delay_us (o_phase_delay_us)
    );

endmodule

// ===== sim/tb_thermocouple_pid_phase_controller_unit.sv =====
// Self-checking testbench: directed table, randomized gain phases and an integral windup run.
`timescale 1ns / 1ps

module tb_thermocouple_pid_phase_controller_unit;
    import tpid_pkg::*;

    localparam int     INTEG_W      = 32;
    localparam longint INTEG_MAX    = (64'sd1 <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN    = -INTEG_MAX - 1;
    localparam longint PRODUCT_CAP  = 64'sd1 <<< 42;
    localparam int     PHASE_COUNT  = 7;
    localparam int     PHASE_ITEMS  = 75;
    // Samples at the largest error that push the integral up under a clamped duty.
    localparam int     WINDUP_ITEMS = 30;
    localparam int     TAIL_CYCLES  = 20;

    // How the temperature of a good sample is spread around the setpoint.
    typedef enum int {
        SPREAD_NEAR,
        SPREAD_WIDE,
        SPREAD_DRIFT
    } t_spread;

    typedef struct {
        int      sp;
        int      gp;
        int      gi;
        int      gd;
        t_spread spread;
    } t_setting;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     fault;
        logic [FAULT_W-1:0]       fault_bits;
        logic [DUTY_W-1:0]        duty;
        logic [DELAY_W-1:0]       delay;
    } t_expect;

    // Fields: raw word, expectation typed in, expected temp/fault/bits/duty/delay.
    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic             typed;
        t_expect          want;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [ADDR_W-1:0]         i_cfg_addr;
    logic [GAIN_W-1:0]         i_cfg_wdata;
    logic                      push;
    logic                      full;
    logic [RAW_W-1:0]          i_raw_word;
    logic                      empty;
    logic                      pop = 1'b0;
    logic signed [TEMP_W-1:0]  o_temperature;
    logic                      o_fault;
    logic [FAULT_W-1:0]        o_fault_bits;
    logic [DUTY_W-1:0]         o_duty;
    logic [DELAY_W-1:0]        o_phase_delay_us;

    thermocouple_pid_phase_controller_unit #(
        .INTEGRAL_WIDTH (INTEG_W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .push             (push),
        .full             (full),
        .i_raw_word       (i_raw_word),
        .empty            (empty),
        .pop              (pop),
        .o_temperature    (o_temperature),
        .o_fault          (o_fault),
        .o_fault_bits     (o_fault_bits),
        .o_duty           (o_duty),
        .o_phase_delay_us (o_phase_delay_us)
    );

    // Controller image kept by the testbench: registers and loop state.
    longint  sp_model;
    longint  gp_model;
    longint  gi_model;
    longint  gd_model;
    longint  integ_model;
    longint  prev_err_model;

    t_expect pending [$];      // results owed by the block, oldest first
    int      fail_count = 0;
    int      result_count = 0;
    bit      tx_gaps_on;
    bit      rx_gaps_on;
    int      rx_hold = 0;

    // Directed rows run under the reset register values. Typed rows are read
    // straight off the spec: faults, the setpoint itself and the temperature rails.
    t_row dir_rows [16] = '{
        '{{14'd720, 18'd0},      1'b1, '{14'sd720, 1'b0, 3'd0, 17'd0, 14'd8300}},
        '{32'hFFFF_FFFF,         1'b1, '{14'sd0,   1'b1, 3'd7, 17'd0, 14'd0}},
        '{32'h0000_0001,         1'b1, '{14'sd0,   1'b1, 3'd1, 17'd0, 14'd0}},
        '{32'h8000_0002,         1'b1, '{14'sd0,   1'b1, 3'd2, 17'd0, 14'd0}},
        '{32'h7FFF_FFFC,         1'b1, '{14'sd0,   1'b1, 3'd4, 17'd0, 14'd0}},
        '{32'h5555_5556,         1'b1, '{14'sd0,   1'b1, 3'd6, 17'd0, 14'd0}},
        '{{14'h2000, 18'h3FFF8}, 1'b1, '{14'h2000, 1'b0, 3'd0, 17'd65536, 14'd0}},
        '{{14'h1FFF, 18'd0},     1'b1, '{14'h1FFF, 1'b0, 3'd0, 17'd0, 14'd8300}},
        '{32'h0000_0000,         1'b0, '0},
        '{{14'd719, 18'd0},      1'b0, '0},
        '{{14'd721, 18'h2AAA8},  1'b0, '0},
        '{{14'd720, 18'd0},      1'b0, '0},
        '{{14'h3FFF, 18'h15550}, 1'b0, '0},
        '{32'hFFFF_FFF8,         1'b0, '0},
        '{32'h0000_0003,         1'b1, '{14'sd0,   1'b1, 3'd3, 17'd0, 14'd0}},
        '{{14'h2000, 18'd0},     1'b0, '0}
    };

    // Fixed register sets for the first random phases; the rest are drawn.
    t_setting fixed_settings [5] = '{
        '{720,   524288,   3932,     1310720,  SPREAD_WIDE},
        '{0,     256,      16,       512,      SPREAD_NEAR},
        '{-8192, 0,        0,        0,        SPREAD_WIDE},
        '{8191,  16777215, 16777215, 16777215, SPREAD_DRIFT},
        '{-300,  1000,     4,        16777215, SPREAD_NEAR}
    };

    // One PID step of the controller image: classify, update state, clamp, map.
    function automatic t_expect predict_step(input logic [RAW_W-1:0] raw);
        t_expect r;
        longint  temp_q;
        longint  err;
        longint  diff;
        longint  mag;
        longint  iterm;
        longint  acc;
        longint  duty;
        r = '0;
        // Fault word: report the bits, leave the loop state alone.
        if (raw[FAULT_W-1:0] != '0) begin
            r.fault      = 1'b1;
            r.fault_bits = raw[FAULT_W-1:0];
            return r;
        end
        temp_q = longint'($signed(raw[RAW_W-1:TEMP_LSB]));
        err    = sp_model - temp_q;
        // Saturate the running sum, no other anti-windup.
        integ_model = integ_model + err;
        if (integ_model > INTEG_MAX) integ_model = INTEG_MAX;
        if (integ_model < INTEG_MIN) integ_model = INTEG_MIN;
        diff           = err - prev_err_model;
        prev_err_model = err;
        // Cap the integral term magnitude at 2^42.
        mag = (integ_model < 0) ? -integ_model : integ_model;
        if (gi_model != 0 && mag > PRODUCT_CAP / gi_model) iterm = PRODUCT_CAP;
        else iterm = mag * gi_model;
        if (integ_model < 0) iterm = -iterm;
        acc = gp_model * err + iterm + gd_model * diff;
        // Clamp to 0..1 in Q16; errors are in quarter degrees, hence the shift by two.
        if (acc <= 0) duty = 0;
        else duty = acc >>> 2;
        if (duty > DUTY_FULL) duty = DUTY_FULL;
        r.temp  = raw[RAW_W-1:TEMP_LSB];
        r.duty  = duty[DUTY_W-1:0];
        r.delay = DELAY_W'(((DUTY_FULL - duty) * HALF_CYCLE_US) >>> DELAY_LSB);
        return r;
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap(input bit on);
        int r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Build a random converter word; about one in seven is a fault word.
    function automatic logic [RAW_W-1:0] make_word(input t_spread spread);
        logic [RAW_W-1:0]  w;
        logic [TEMP_W-1:0] t;
        w = $urandom;
        if ($urandom_range(0, 99) < 15) begin
            if (w[FAULT_W-1:0] == '0) w[FAULT_W-1:0] = FAULT_W'($urandom_range(1, 7));
            return w;
        end
        case (spread)
            SPREAD_NEAR:  t = TEMP_W'(sp_model + longint'(int'($urandom_range(0, 128)) - 64));
            SPREAD_DRIFT: t = TEMP_W'(int'($urandom_range(0, 8191)) - 8192);
            default:      t = TEMP_W'($urandom);
        endcase
        return {t, w[TEMP_LSB-1:FAULT_W], {FAULT_W{1'b0}}};
    endfunction

    function automatic void flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", msg);
    endfunction

    // Offer one request, hold it until taken, then log what the block owes for it.
    task automatic send_request(input logic [RAW_W-1:0] raw, input bit typed,
                                input t_expect given);
        t_expect want;
        push       <= 1'b1;
        i_raw_word <= raw;
        do @(posedge i_clk); while (full);
        want = predict_step(raw);
        pending.push_back(typed ? given : want);
    endtask

    task automatic tx_gap();
        int n;
        n = pick_gap(tx_gaps_on);
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drop push and hold until every owed result has been taken.
    task automatic drain();
        push <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    // Write all four registers, one per cycle; the setpoint carries junk above bit 13.
    task automatic load_setting(input t_setting s);
        t_reg_idx          idx;
        logic [GAIN_W-1:0] data;
        for (int k = 0; k < 4; k++) begin
            idx = t_reg_idx'(k);
            case (idx)
                REG_SETPOINT: begin
                    data               = GAIN_W'($urandom);
                    data[TEMP_W-1:0]   = s.sp[TEMP_W-1:0];
                    sp_model           = longint'($signed(data[TEMP_W-1:0]));
                end
                REG_GAIN_PROP: begin
                    data     = s.gp[GAIN_W-1:0];
                    gp_model = longint'(data);
                end
                REG_GAIN_INTEG: begin
                    data     = s.gi[GAIN_W-1:0];
                    gi_model = longint'(data);
                end
                default: begin
                    data     = s.gd[GAIN_W-1:0];
                    gd_model = longint'(data);
                end
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx;
            i_cfg_wdata <= data;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Result side: check each taken result against the oldest owed one,
    // and stall pop at random in between.
    always @(posedge i_clk) begin
        t_expect want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                result_count++;
                if (pending.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with none owed (temp=%0d)",
                                         result_count, o_temperature));
                end else begin
                    want = pending.pop_front();
                    if (o_temperature !== want.temp || o_fault !== want.fault ||
                        o_fault_bits !== want.fault_bits || o_duty !== want.duty ||
                        o_phase_delay_us !== want.delay)
                        flag_error($sformatf(
                            {"result %0d exp t=%0d f=%0b fb=%0d duty=%0d dly=%0d, ",
                             "got t=%0d f=%0b fb=%0d duty=%0d dly=%0d"},
                            result_count, want.temp, want.fault, want.fault_bits, want.duty,
                            want.delay, o_temperature, o_fault, o_fault_bits, o_duty,
                            o_phase_delay_us));
                end
            end
            if (rx_hold != 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                rx_hold = pick_gap(rx_gaps_on);
            end
        end
    end

    // Request side: reset, directed table, random phases, windup, release, wrap up.
    initial begin
        t_setting         s;
        logic [RAW_W-1:0] raw;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_wdata <= '0;
        push        <= 1'b0;
        i_raw_word  <= '0;
        tx_gaps_on  = 1'b1;
        rx_gaps_on  = 1'b1;
        // Mirror the reset register values and cleared loop state.
        sp_model       = 720;
        gp_model       = 524288;
        gi_model       = 3932;
        gd_model       = 1310720;
        integ_model    = 0;
        prev_err_model = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under reset values: faults, rails, the setpoint itself.
        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].raw, dir_rows[i].typed, dir_rows[i].want);
            tx_gap();
        end
        drain();

        // Random phases; each starts from an idle block with a fresh register set.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph < 5) begin
                s = fixed_settings[ph];
            end else begin
                s.sp     = int'($urandom_range(0, 16383)) - 8192;
                s.gp     = (ph == 5) ? $urandom_range(0, 4096) : $urandom_range(0, 16777215);
                s.gi     = (ph == 5) ? $urandom_range(0, 64)   : $urandom_range(0, 16777215);
                s.gd     = (ph == 5) ? $urandom_range(0, 4096) : $urandom_range(0, 16777215);
                s.spread = (ph == 5) ? SPREAD_NEAR : SPREAD_WIDE;
            end
            load_setting(s);
            // Leave one side free of idling in some phases.
            tx_gaps_on = (ph != 2);
            rx_gaps_on = (ph != 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(make_word(s.spread), 1'b0, '0);
                tx_gap();
                // Hold the sender once mid-phase until every result is out.
                if (ph == 1 && n == 40) drain();
            end
            drain();
        end

        // Windup: largest positive error at full speed; the sum climbs, duty stays clamped.
        load_setting('{8191, 524288, 3932, 1310720, SPREAD_DRIFT});
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        repeat (WINDUP_ITEMS) begin
            raw = {14'h2000, 15'($urandom), 3'b000};
            send_request(raw, 1'b0, '0);
        end
        // Zero error: the sum must hold still.
        repeat (4) begin
            raw = {14'h1FFF, 15'($urandom), 3'b000};
            send_request(raw, 1'b0, '0);
        end
        drain();

        // Release: largest negative error walks the sum back down.
        load_setting('{-8192, 524288, 3932, 1310720, SPREAD_WIDE});
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        repeat (20) begin
            raw = {14'h1FFF, 15'($urandom), 3'b000};
            send_request(raw, 1'b0, '0);
            tx_gap();
        end
        drain();

        // Give any stray result time to show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
